@@ design/utf8dec_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8dec_pkg
// Shared types, constants and helpers of the UTF-8 to UCS-2 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8dec_pkg;

    localparam int ACC_W  = 31;
    localparam int UNIT_W = 16;

    // Stand-in for any value that does not fit in 16 bits ('?')
    localparam logic [UNIT_W-1:0] SUBST_CHAR = 16'h003F;

    // Why a result closes the string
    typedef enum logic [2:0] {
        REASON_NONE    = 3'd0,
        REASON_ZERO    = 3'd1,
        REASON_BADCONT = 3'd2,
        REASON_TRUNC   = 3'd3,
        REASON_BUFEND  = 3'd4
    } end_reason_t;

    // Leading ones of a lead byte; seven or more report as 7
    function automatic logic [2:0] lead_ones(input logic [7:0] b);
        logic [2:0] cnt;
        priority if (!b[7]) cnt = 3'd0;
        else if (!b[6])     cnt = 3'd1;
        else if (!b[5])     cnt = 3'd2;
        else if (!b[4])     cnt = 3'd3;
        else if (!b[3])     cnt = 3'd4;
        else if (!b[2])     cnt = 3'd5;
        else if (!b[1])     cnt = 3'd6;
        else                cnt = 3'd7;
        return cnt;
    endfunction

    // Value bits of a lead byte, placed for the given sequence length
    function automatic logic [ACC_W-1:0] lead_bits(input logic [7:0] b,
                                                   input logic [2:0] cnt);
        logic [ACC_W-1:0] acc;
        unique case (cnt)
            3'd2:    acc = {20'd0, b[4:0], 6'd0};
            3'd3:    acc = {15'd0, b[3:0], 12'd0};
            3'd4:    acc = {10'd0, b[2:0], 18'd0};
            3'd5:    acc = {5'd0, b[1:0], 24'd0};
            3'd6:    acc = {b[0], 30'd0};
            default: acc = '0;
        endcase
        return acc;
    endfunction

    // Six continuation bits placed by the count of bytes still to come
    function automatic logic [ACC_W-1:0] cont_bits(input logic [5:0] bits,
                                                   input logic [2:0] left);
        logic [ACC_W-1:0] acc;
        unique case (left)
            3'd0:    acc = {25'd0, bits};
            3'd1:    acc = {19'd0, bits, 6'd0};
            3'd2:    acc = {13'd0, bits, 12'd0};
            3'd3:    acc = {7'd0, bits, 18'd0};
            3'd4:    acc = {1'd0, bits, 24'd0};
            default: acc = '0;
        endcase
        return acc;
    endfunction

endpackage

`default_nettype wire

@@ design/utf8_to_ucs2_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_unit
// Byte-stream UTF-8 decoder producing 16-bit code units with end status.
// ----------------------------------------------------------------------------
// Usage:
//   Byte channel (byte_valid / byte_stall): one UTF-8 byte per item with
//   last_byte marking the final byte of the buffer.
//   Char channel (char_valid / char_stall): zero or one result per byte,
//   carrying has_char, code_unit, done_res and end_reason.
//   A byte is taken every cycle while byte_stall is low; its result, if any,
//   shows on the char channel in the cycle after the byte is accepted. Sustained
//   rate is one byte per cycle while char_stall is low, set by the combinational
//   update of the pending count and accumulator feeding the result register.
//   While a result sits unaccepted and char_stall is high, byte_stall is
//   raised and the decoder holds; the result register then frees as soon
//   as the receiver takes it.
//   Reset clears the pending count, accumulator, drain flag and the result
//   valid; decoding starts at the first byte of a new buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_ucs2_decoder_unit
    import utf8dec_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // byte channel
    input  wire logic              byte_valid,
    output logic                   byte_stall,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    // char channel
    output logic                   char_valid,
    input  wire logic              char_stall,
    output logic                   has_char,
    output logic [UNIT_W-1:0]      code_unit,
    output logic                   done_res,
    output logic [2:0]             end_reason
);

    // decoder state
    logic [2:0]       pending_reg, pending_next;
    logic [ACC_W-1:0] accum_reg, accum_next;
    logic             draining_reg, draining_next;

    // result register
    logic              char_valid_reg;
    logic              has_char_reg;
    logic [UNIT_W-1:0] code_unit_reg;
    logic              done_res_reg;
    end_reason_t       end_reason_reg;

    logic              accept;
    logic              out_load;
    logic              emit;
    logic              r_has;
    logic [UNIT_W-1:0] r_unit;
    logic              r_done;
    end_reason_t       r_reason;

    // handshake
    assign byte_stall = char_valid_reg && char_stall;
    assign accept     = byte_valid && !byte_stall;
    assign out_load   = !char_valid_reg || !char_stall;

    // per-byte decode
    always_comb
    begin
        logic [2:0]        cnt;
        logic [2:0]        left;
        logic [ACC_W-1:0]  merged;
        logic              fin;
        logic [ACC_W-1:0]  fin_value;
        logic [UNIT_W-1:0] fin_unit;

        pending_next  = pending_reg;
        accum_next    = accum_reg;
        draining_next = draining_reg;
        emit          = 1'b0;
        r_has         = 1'b0;
        r_unit        = '0;
        r_done        = 1'b0;
        r_reason      = REASON_NONE;
        fin           = 1'b0;
        fin_value     = '0;
        cnt           = lead_ones(data_byte);
        left          = pending_reg - 3'd1;
        merged        = accum_reg | cont_bits(data_byte[5:0], left);

        if (accept)
        begin
            if (draining_reg)
            begin
                if (last_byte)
                    draining_next = 1'b0;
            end
            else if (pending_reg == 3'd0)
            begin
                if (cnt == 3'd1 || cnt == 3'd7)
                begin
                    // lone continuation or 0xFE/0xFF: skipped
                    if (last_byte)
                    begin
                        emit     = 1'b1;
                        r_done   = 1'b1;
                        r_reason = REASON_BUFEND;
                    end
                end
                else if (cnt == 3'd0)
                begin
                    fin       = 1'b1;
                    fin_value = {{(ACC_W-8){1'b0}}, data_byte};
                end
                else if (last_byte)
                begin
                    // sequence opened on the final byte
                    pending_next = 3'd0;
                    accum_next   = '0;
                    emit         = 1'b1;
                    r_done       = 1'b1;
                    r_reason     = REASON_TRUNC;
                end
                else
                begin
                    pending_next = cnt - 3'd1;
                    accum_next   = lead_bits(data_byte, cnt);
                end
            end
            else if (data_byte[7:6] != 2'b10)
            begin
                // broken sequence
                pending_next  = 3'd0;
                accum_next    = '0;
                draining_next = !last_byte;
                emit          = 1'b1;
                r_done        = 1'b1;
                r_reason      = REASON_BADCONT;
            end
            else if (left == 3'd0)
            begin
                pending_next = 3'd0;
                accum_next   = '0;
                fin          = 1'b1;
                fin_value    = merged;
            end
            else if (last_byte)
            begin
                pending_next = 3'd0;
                accum_next   = '0;
                emit         = 1'b1;
                r_done       = 1'b1;
                r_reason     = REASON_TRUNC;
            end
            else
            begin
                pending_next = left;
                accum_next   = merged;
            end
        end

        // completed character
        fin_unit = (|fin_value[ACC_W-1:UNIT_W]) ? SUBST_CHAR : fin_value[UNIT_W-1:0];
        if (fin)
        begin
            emit   = 1'b1;
            r_has  = 1'b1;
            r_unit = fin_unit;
            if (fin_unit == '0)
            begin
                draining_next = !last_byte;
                r_done        = 1'b1;
                r_reason      = REASON_ZERO;
            end
            else if (last_byte)
            begin
                r_done   = 1'b1;
                r_reason = REASON_BUFEND;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= 3'd0;
            accum_reg      <= '0;
            draining_reg   <= 1'b0;
            char_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg  <= pending_next;
            accum_reg    <= accum_next;
            draining_reg <= draining_next;
            if (out_load)
                char_valid_reg <= emit;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            has_char_reg   <= r_has;
            code_unit_reg  <= r_unit;
            done_res_reg   <= r_done;
            end_reason_reg <= r_reason;
        end
    end

    assign char_valid = char_valid_reg;
    assign has_char   = has_char_reg;
    assign code_unit  = code_unit_reg;
    assign done_res   = done_res_reg;
    assign end_reason = end_reason_reg;

    // checks
    a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd5)
        else $error("pending count out of range");

    a_drain_clean: assert property (@(posedge clk) disable iff (!rst_n)
        draining_reg |-> (pending_reg == 3'd0 && accum_reg == '0))
        else $error("draining with a partial sequence held");

    a_nochar_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid_reg && !has_char_reg) |-> done_res_reg)
        else $error("result without character does not close string");

    a_open_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid_reg && !done_res_reg) |->
            (has_char_reg && code_unit_reg != '0 && end_reason_reg == REASON_NONE))
        else $error("open result carries zero or reason");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 to UCS-2 decoder. A scoreboard tracks the
// decoder state byte by byte, predicts each code unit and end status, and
// compares the char channel against it in order. The stimulus has a short
// directed buffer set, then random buffers of mostly well-formed characters.
// Random gaps on the byte side and random stalls on the char side are mixed in.
// ----------------------------------------------------------------------------
module tb_top
    import utf8dec_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              has;
        logic [UNIT_W-1:0] unit;
        logic              done;
        end_reason_t       reason;
    } char_result_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } utf8_byte_t;

    // Predicts decoder results and checks them in arrival order
    class utf8_char_scoreboard;
        logic [2:0]   conts_left;
        logic [30:0]  code_acc;
        bit           skipping;
        char_result_t predicted_chars[$];
        int           errors;

        function new();
            conts_left = '0;
            code_acc   = '0;
            skipping   = 1'b0;
            errors     = 0;
        endfunction

        function void push_result(bit has, logic [UNIT_W-1:0] unit, bit done,
                                  end_reason_t reason);
            char_result_t r;
            r.has    = has;
            r.unit   = unit;
            r.done   = done;
            r.reason = reason;
            predicted_chars.push_back(r);
        endfunction

        // Completed character: substitute wide values, close on zero or last
        function void close_char(logic [31:0] value, bit last);
            logic [UNIT_W-1:0] unit;
            unit = (value[31:16] != '0) ? SUBST_CHAR : value[15:0];
            if (unit == '0) begin
                skipping = !last;
                push_result(1'b1, '0, 1'b1, REASON_ZERO);
            end
            else if (last)
                push_result(1'b1, unit, 1'b1, REASON_BUFEND);
            else
                push_result(1'b1, unit, 1'b0, REASON_NONE);
        endfunction

        // Notes one accepted byte; returns 0 when the byte is only drained
        function bit note_byte(logic [7:0] b, bit last);
            int          ones;
            logic [31:0] bits32;
            if (skipping) begin
                if (last)
                    skipping = 1'b0;
                return 1'b0;
            end
            // lead byte
            if (conts_left == '0) begin
                ones = 0;
                while (ones < 7 && b[7 - ones])
                    ones++;
                if (ones == 1 || ones > 6) begin
                    if (last)
                        push_result(1'b0, '0, 1'b1, REASON_BUFEND);
                    return 1'b1;
                end
                if (ones == 0) begin
                    close_char({24'd0, b}, last);
                    return 1'b1;
                end
                bits32     = (32'(b) & ((32'd1 << (7 - ones)) - 1)) << ((ones - 1) * 6);
                code_acc   = bits32[30:0];
                conts_left = 3'(ones - 1);
                if (last) begin
                    conts_left = '0;
                    code_acc   = '0;
                    push_result(1'b0, '0, 1'b1, REASON_TRUNC);
                end
                return 1'b1;
            end
            // continuation byte expected
            if (b[7:6] != 2'b10) begin
                conts_left = '0;
                code_acc   = '0;
                skipping   = !last;
                push_result(1'b0, '0, 1'b1, REASON_BADCONT);
                return 1'b1;
            end
            conts_left = conts_left - 3'd1;
            bits32     = 32'(b[5:0]) << (conts_left * 6);
            code_acc   = code_acc | bits32[30:0];
            if (conts_left == '0) begin
                bits32   = {1'b0, code_acc};
                code_acc = '0;
                close_char(bits32, last);
            end
            else if (last) begin
                conts_left = '0;
                code_acc   = '0;
                push_result(1'b0, '0, 1'b1, REASON_TRUNC);
            end
            return 1'b1;
        endfunction

        function void check_char(char_result_t got);
            char_result_t want;
            if (predicted_chars.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result has=%0b unit=%h done=%0b reason=%0d",
                             got.has, got.unit, got.done, got.reason);
                return;
            end
            want = predicted_chars.pop_front();
            if (got.has != want.has || got.unit != want.unit ||
                got.done != want.done || got.reason != want.reason) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: expected has=%0b unit=%h done=%0b reason=%0d, got has=%0b unit=%h done=%0b reason=%0d",
                             want.has, want.unit, want.done, want.reason,
                             got.has, got.unit, got.done, got.reason);
            end
        endfunction

        // Anything still predicted at the end never arrived
        function int final_errors();
            if (predicted_chars.size() != 0) begin
                errors += predicted_chars.size();
                $display("ERROR: %0d expected results never arrived",
                         predicted_chars.size());
            end
            return errors;
        endfunction
    endclass

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              byte_valid = 1'b0;
    logic              byte_stall;
    logic [7:0]        data_byte  = 8'h00;
    logic              last_byte  = 1'b0;
    logic              char_valid;
    logic              char_stall = 1'b0;
    logic              has_char;
    logic [UNIT_W-1:0] code_unit;
    logic              done_res;
    logic [2:0]        end_reason;

    utf8_char_scoreboard sb;
    utf8_byte_t          tx_q[$];
    int                  decoded_bytes = 0;

    // sender burst shaping
    int burst_left = 0;
    int burst_max  = 1;
    int gap_max    = 0;

    // receiver stall shaping
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int regime      = 0;
    int regime_left = 0;
    int run_left    = 0;
    bit stalling    = 1'b0;

    utf8_to_ucs2_decoder_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .has_char   (has_char),
        .code_unit  (code_unit),
        .done_res   (done_res),
        .end_reason (end_reason)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Drive one byte and wait until it is taken
    task automatic send_byte(logic [7:0] b, bit last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            if (gap_max != 0 && hold_left == 0) begin
                byte_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
        end
        burst_left--;
        byte_valid <= 1'b1;
        data_byte  <= b;
        last_byte  <= last;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        if (sb.note_byte(b, last))
            decoded_bytes++;
    endtask

    // Pause the sender until every predicted result is back
    task automatic wait_drained();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (sb.predicted_chars.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Lead byte for a sequence of len bytes (len 1 is plain ASCII), then n_conts
    function automatic void put_seq(int len, int n_conts);
        utf8_byte_t item;
        item.last = 1'b0;
        if (len == 1)
            item.data = 8'($urandom_range(1, 127));
        else
            item.data = ~(8'hFF >> len) | (8'($urandom) & ((8'd1 << (7 - len)) - 8'd1));
        tx_q.push_back(item);
        for (int k = 0; k < n_conts; k++) begin
            item.data = 8'h80 | (8'($urandom) & 8'h3F);
            tx_q.push_back(item);
        end
    endfunction

    function automatic void put_raw(logic [7:0] b);
        utf8_byte_t item;
        item.data = b;
        item.last = 1'b0;
        tx_q.push_back(item);
    endfunction

    // One random buffer: mostly good characters, some broken ones
    function automatic void gen_buffer();
        int         n_chars;
        int         kind;
        int         len;
        int         r;
        logic [7:0] nb;
        utf8_byte_t tail;
        n_chars = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
        for (int i = 0; i < n_chars; i++) begin
            kind = $urandom_range(0, 99);
            r    = $urandom_range(0, 99);
            len  = (r < 35) ? 1 : (r < 60) ? 2 : (r < 80) ? 3 : (r < 90) ? 4 : (r < 95) ? 5 : 6;
            if (kind < 84)
                put_seq(len, len - 1);
            else if (kind < 88)
                put_raw(8'h80 | (8'($urandom) & 8'h3F));
            else if (kind < 91)
                put_raw($urandom_range(0, 1) ? 8'hFF : 8'hFE);
            else if (kind < 94) begin
                // zero, plain or overlong
                case ($urandom_range(0, 2))
                    0: put_raw(8'h00);
                    1: begin put_raw(8'hC0); put_raw(8'h80); end
                    default: begin put_raw(8'hE0); put_raw(8'h80); put_raw(8'h80); end
                endcase
            end
            else if (kind < 97) begin
                // bad continuation inside a multi-byte sequence
                len = $urandom_range(2, 6);
                put_seq(len, $urandom_range(0, len - 2));
                do nb = 8'($urandom); while (nb[7:6] == 2'b10);
                put_raw(nb);
            end
            else begin
                len = $urandom_range(2, 6);
                put_seq(len, $urandom_range(0, len - 2));
            end
        end
        // sometimes end the buffer inside a sequence
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(2, 6);
            put_seq(len, $urandom_range(0, len - 2));
        end
        tail = tx_q.pop_back();
        tail.last = 1'b1;
        tx_q.push_back(tail);
    endfunction

    // Receiver: checks results and stalls on its own schedule
    always @(posedge clk) begin : char_side
        char_result_t got;
        if (rst_n) begin
            if (char_valid && !char_stall) begin
                got.has    = has_char;
                got.unit   = code_unit;
                got.done   = done_res;
                got.reason = end_reason_t'(end_reason);
                sb.check_char(got);
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 500;
            end
            if (hold_left > 0) begin
                hold_left--;
                char_stall <= 1'b1;
            end
            else begin
                if (regime_left == 0) begin
                    regime_left = 256;
                    regime      = $urandom_range(0, 3);
                end
                regime_left--;
                if (run_left == 0) begin
                    stalling = !stalling;
                    case (regime)
                        1: run_left = stalling ? $urandom_range(1, 2) : $urandom_range(1, 8);
                        2: run_left = stalling ? $urandom_range(1, 6) : $urandom_range(1, 3);
                        3: run_left = stalling ? $urandom_range(1, 12) : 1;
                        default: run_left = $urandom_range(1, 16);
                    endcase
                end
                run_left--;
                char_stall <= (regime != 0) && stalling;
            end
        end
    end

    // Directed buffers, bit 8 marks the last byte
    logic [8:0] directed_seq[] = '{
        9'h041, 9'h0DF, 9'h0BF, 9'h0EF, 9'h0BF, 9'h0BF,          // ASCII, 2- and 3-byte max
        9'h080, 9'h0FE, 9'h0FF,                                    // skipped bytes
        9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF,           // 6-byte max, wide
        9'h142,                                                    // char on last byte
        9'h1FF,                                                    // skipped byte as last
        9'h0C0, 9'h080, 9'h041, 9'h100,                            // overlong zero, drain
        9'h0E2, 9'h041, 9'h180,                                    // bad continuation, drain
        9'h1C3,                                                    // lead on last byte
        9'h0E2, 9'h182,                                            // truncated mid sequence
        9'h100                                                     // zero on last byte
    };

    initial begin : stim
        int         buffers;
        utf8_byte_t item;
        buffers = 0;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_seq[i])
            send_byte(directed_seq[i][7:0], directed_seq[i][8]);
        wait_drained();

        while (decoded_bytes < 1850) begin
            case ($urandom_range(0, 3))
                0: begin burst_max = 1; gap_max = 0; end
                1: begin burst_max = 3; gap_max = 2; end
                2: begin burst_max = 8; gap_max = 6; end
                default: begin burst_max = 2; gap_max = 8; end
            endcase
            gen_buffer();
            while (tx_q.size() != 0) begin
                item = tx_q.pop_front();
                send_byte(item.data, item.last);
            end
            buffers++;
            // long receiver hold while bytes keep coming
            if (buffers == 40 || buffers == 120)
                hold_req <= hold_req + 1;
            if (buffers % 40 == 25)
                wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.final_errors() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin : watchdog
        #1000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
